// File: rtl/core/dsfp_pkg.sv
// Package for the dominant symbol fraction penalty unit.
// Holds the request and result structs, the state encoding and fixed widths.
// No dependencies.
package dsfp_pkg;

  localparam int SYM_W     = 6;
  localparam int NUM_W     = 16;
  localparam int SCALE_W   = 24;
  localparam int CUT_W     = 17;
  localparam int PEN_W     = 25;
  localparam int CFG_W     = 24;
  localparam int IDX_W     = 2;
  localparam int DIV_STEPS = 17;

  localparam logic [CUT_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [IDX_W-1:0] CFG_SCALE  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_CUTOFF = 2'd1;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } dsfp_sym_t;

  typedef struct packed {
    logic signed [PEN_W-1:0] penalty;
    logic                    overflow;
  } dsfp_res_t;

  typedef enum logic [3:0] {
    S_RUN,
    S_DRAIN,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_DIV,
    S_SQ,
    S_PLO,
    S_PHI,
    S_RND,
    S_DONE
  } dsfp_state_t;

endpackage

// File: rtl/core/dominant_symbol_fraction_penalty_unit.sv
// Top level of the dominant symbol fraction penalty unit.
// Holds the histogram memory, the per-sequence sequencer and the result register.
// Depends on dsfp_pkg.

// Symbols are taken one per clock cycle while the input is open: each request reads its
// histogram bin from a memory with one read and one write port and a registered read,
// and writes the incremented count back in the next cycle, with the last write forwarded
// when the same symbol follows directly.
// After the request marked last the input stays closed while the penalty is computed:
// through the 17-step restoring divider, the squaring and the split multiplication by
// the scale when the fraction reaches a cutoff below one, else straight to the result,
// and further while the previous result still waits to be taken. The histogram carries
// one valid bit per entry, so clearing it at the end of a sequence needs no pass over the
// memory. A finished result waits in the output register while the next sequence is
// accepted.
module dominant_symbol_fraction_penalty_unit
  import dsfp_pkg::*;
#(
  parameter int ALPHABET = 64,
  parameter int MAX_LEN  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sym_valid,
  output logic             sym_ready,
  input  dsfp_sym_t        sym,
  output logic             res_valid,
  input  logic             res_ready,
  output dsfp_res_t        res,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(ALPHABET);
  localparam int LW = $clog2(MAX_LEN + 1);

  dsfp_state_t state, state_next;

  logic [SCALE_W-1:0] scale;
  logic [CUT_W-1:0]   cutoff;

  logic [LW-1:0] mem [ALPHABET];
  logic [LW-1:0] rd_data;
  logic [ALPHABET-1:0] ent_vld;

  logic          s2_vld;
  logic          s2_count;
  logic [AW-1:0] s2_addr;
  logic          fwd_vld;
  logic [AW-1:0] fwd_addr;
  logic [LW-1:0] fwd_data;

  logic [LW-1:0] largest;
  logic [LW-1:0] len;
  logic          saturated;

  logic [NUM_W-1:0] m_q;
  logic [NUM_W-1:0] n_q;
  logic             sat_q;
  logic [32:0]      cn;
  logic [31:0]      den;
  logic [32:0]      rem;
  logic [DIV_STEPS-1:0] quot;
  logic [4:0]       div_cnt;
  logic [32:0]      rr;
  logic [39:0]      plo;
  logic [40:0]      phi;
  logic [PEN_W-1:0] mag;

  logic          sym_fire;
  logic          in_alpha;
  logic          not_full;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [LW-1:0] cnt_old;
  logic [LW-1:0] cnt_new;
  logic          seq_clear;
  logic          res_load;
  logic          zero_pen;
  logic [31:0]   m_sh;
  logic [32:0]   den_prod;
  logic [32:0]   trial;
  logic          ge;
  logic [56:0]   sum;

  assign sym_fire = sym_valid && sym_ready;
  assign in_alpha = 32'(sym.symbol) < 32'(ALPHABET);
  assign not_full = len < LW'(MAX_LEN);
  assign rd_addr  = AW'(sym.symbol);
  assign wr_en    = s2_vld && s2_count;

  always_comb begin
    if (!ent_vld[s2_addr]) begin
      cnt_old = '0;
    end else if (fwd_vld && (fwd_addr == s2_addr)) begin
      cnt_old = fwd_data;
    end else begin
      cnt_old = rd_data;
    end
    cnt_new = cnt_old + LW'(1);
  end

  assign m_sh     = {m_q, 16'b0};
  assign den_prod = {16'b0, n_q} * {16'b0, 17'(ONE_Q16 - cutoff)};
  assign zero_pen = (n_q == '0) || cutoff[CUT_W-1] || ({1'b0, m_sh} < cn);
  assign trial    = (div_cnt == '0) ? rem : {rem[31:0], 1'b0};
  assign ge       = trial >= {1'b0, den};
  assign sum      = {phi, 16'b0} + {17'b0, plo} + (57'd1 << 31);

  always_comb begin
    state_next = state;
    case (state)
      S_RUN: begin
        if (sym_fire && sym.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_CMP;
      S_CMP:   state_next = zero_pen ? S_DONE : S_DIV;
      S_DIV: begin
        if (div_cnt == 5'(DIV_STEPS - 1)) begin
          state_next = S_SQ;
        end
      end
      S_SQ:  state_next = S_PLO;
      S_PLO: state_next = S_PHI;
      S_PHI: state_next = S_RND;
      S_RND: state_next = S_DONE;
      S_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_comb begin
    sym_ready = 1'b0;
    seq_clear = 1'b0;
    res_load  = 1'b0;
    case (state)
      S_RUN:  sym_ready = 1'b1;
      S_MUL1: seq_clear = 1'b1;
      S_DONE: res_load  = !res_valid || res_ready;
      default: begin
        sym_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale  <= '0;
      cutoff <= 17'h08000;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SCALE) begin
        scale <= cfg_data[SCALE_W-1:0];
      end else if (cfg_index == CFG_CUTOFF) begin
        cutoff <= cfg_data[CUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s2_addr] <= cnt_new;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld    <= 1'b0;
      fwd_vld   <= 1'b0;
      ent_vld   <= '0;
      largest   <= '0;
      len       <= '0;
      saturated <= 1'b0;
    end else begin
      s2_vld  <= sym_fire;
      fwd_vld <= wr_en;
      if (seq_clear) begin
        ent_vld   <= '0;
        largest   <= '0;
        len       <= '0;
        saturated <= 1'b0;
      end else begin
        if (sym_fire) begin
          if (not_full) begin
            len <= len + LW'(1);
          end else begin
            saturated <= 1'b1;
          end
        end
        if (wr_en) begin
          ent_vld[s2_addr] <= 1'b1;
          if (cnt_new > largest) begin
            largest <= cnt_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_addr  <= rd_addr;
    s2_count <= not_full && in_alpha;
    fwd_addr <= s2_addr;
    fwd_data <= cnt_new;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_MUL1: begin
        m_q   <= NUM_W'(largest);
        n_q   <= NUM_W'(len);
        sat_q <= saturated;
        cn    <= {16'b0, cutoff} * {17'b0, NUM_W'(len)};
      end
      S_MUL2: den <= den_prod[31:0];
      S_CMP: begin
        rem     <= {1'b0, m_sh - cn[31:0]};
        quot    <= '0;
        div_cnt <= '0;
        mag     <= '0;
      end
      S_DIV: begin
        rem     <= ge ? (trial - {1'b0, den}) : trial;
        quot    <= {quot[DIV_STEPS-2:0], ge};
        div_cnt <= div_cnt + 5'd1;
      end
      S_SQ:  rr  <= 33'({17'b0, quot} * {17'b0, quot});
      S_PLO: plo <= {16'b0, scale} * {24'b0, rr[15:0]};
      S_PHI: phi <= {17'b0, scale} * {24'b0, rr[32:16]};
      S_RND: mag <= sum[56:32];
      default: begin
        div_cnt <= div_cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.penalty  <= PEN_W'(0) - mag;
      res.overflow <= sat_q;
    end
  end

  a_largest_bounded: assert property (@(posedge clk) disable iff (rst)
    largest <= len)
    else $error("largest count exceeds sequence length");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt != '0) |-> (rem < {1'b0, den}))
    else $error("divider remainder not below divisor");

  a_mag_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ({1'b0, mag} <= {2'b0, scale}))
    else $error("penalty magnitude exceeds scale");

  a_penalty_sign: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.penalty <= 0))
    else $error("penalty is positive");

endmodule

// File: sim/dsfp_penalty_checker.sv
// Checker for the dominant symbol fraction penalty unit: watches the request, result and
// register ports, predicts each penalty and compares it with what the unit returns.
// Depends on dsfp_pkg.
module dsfp_penalty_checker
  import dsfp_pkg::*;
#(
  parameter int ALPHABET = 64,
  parameter int MAX_LEN  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sym_valid,
  input  logic             sym_ready,
  input  dsfp_sym_t        sym,
  input  logic             res_valid,
  input  logic             res_ready,
  input  dsfp_res_t        res,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatches,
  output int               outstanding
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam longint unsigned UNITY = 65536;

  logic [SCALE_W-1:0] scale;
  logic [CUT_W-1:0]   cutoff;
  logic [CNT_W-1:0]   bin_count [ALPHABET];
  logic [CNT_W-1:0]   largest;
  logic [CNT_W-1:0]   seq_len;
  bit                 saturated;
  int                 failures;
  dsfp_res_t          expected_results [$];

  function automatic logic [PEN_W-1:0] predicted_penalty(longint unsigned m, longint unsigned n);
    longint unsigned c, s, d, ratio, magnitude;
    c = cutoff;
    s = scale;
    if (n == 0 || c >= UNITY) return '0;
    if (m * UNITY < c * n) return '0;
    d = m * UNITY - c * n;
    ratio = (d * UNITY) / (n * (UNITY - c));
    if (ratio > UNITY) ratio = UNITY;
    magnitude = (s * (ratio * ratio) + 64'h8000_0000) >> 32;
    return -magnitude[PEN_W-1:0];
  endfunction

  task automatic clear_histogram();
    foreach (bin_count[i]) bin_count[i] = '0;
    largest = '0;
    seq_len = '0;
    saturated = 1'b0;
  endtask

  task automatic count_symbol(dsfp_sym_t s);
    dsfp_res_t want;
    if (seq_len >= MAX_LEN) begin
      saturated = 1'b1;
    end else begin
      seq_len = seq_len + 1'b1;
      if (s.symbol < ALPHABET) begin
        bin_count[s.symbol] = bin_count[s.symbol] + 1'b1;
        if (bin_count[s.symbol] > largest) largest = bin_count[s.symbol];
      end
    end
    if (s.last) begin
      want.penalty = predicted_penalty(largest, seq_len);
      want.overflow = saturated;
      expected_results = {expected_results, want};
      clear_histogram();
    end
  endtask

  always @(posedge clk) begin : monitor
    dsfp_res_t want;
    if (rst) begin
      scale = '0;
      cutoff = ONE_Q16 >> 1;
      clear_histogram();
      expected_results.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCALE: begin
            scale = cfg_data[SCALE_W-1:0];
          end
          CFG_CUTOFF: begin
            cutoff = cfg_data[CUT_W-1:0];
          end
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          if (failures < 10)
            $display("unexpected result: penalty %0d overflow %0b",
                     res.penalty, res.overflow);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (res.penalty !== want.penalty || res.overflow !== want.overflow) begin
            if (failures < 10)
              $display({"result mismatch: expected penalty %0d overflow %0b, ",
                        "got penalty %0d overflow %0b"},
                       want.penalty, want.overflow, res.penalty, res.overflow);
            failures++;
          end
        end
      end
      if (sym_valid && sym_ready) count_symbol(sym);
    end
    mismatches <= failures;
    outstanding <= expected_results.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the testbench for the dominant symbol fraction penalty unit: clock, reset,
// request and register stimulus, result stalls and the final verdict.
// Depends on dsfp_pkg, the unit itself and dsfp_penalty_checker.
module testbench;
  import dsfp_pkg::*;

  localparam int SEQ_LIMIT = 1024;
  localparam int CODE_MAX  = (1 << SYM_W) - 1;
  localparam logic [IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             sym_valid = 1'b0;
  logic             sym_ready;
  dsfp_sym_t        sym = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  dsfp_res_t        res;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent_in_phase = 0;
  bit hold_off = 1'b0;

  always #4 clk = ~clk;

  dominant_symbol_fraction_penalty_unit #(.ALPHABET(64), .MAX_LEN(SEQ_LIMIT)) dut (
    .clk(clk), .rst(rst),
    .sym_valid(sym_valid), .sym_ready(sym_ready), .sym(sym),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dsfp_penalty_checker #(.ALPHABET(64), .MAX_LEN(SEQ_LIMIT)) penalty_checker (
    .clk(clk), .rst(rst),
    .sym_valid(sym_valid), .sym_ready(sym_ready), .sym(sym),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // The long hold-off lets the result register fill so that the unit must refuse requests.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        res_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(logic [SYM_W-1:0] code, logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      sym_valid <= 1'b0;
      @(posedge clk);
    end
    sym_valid <= 1'b1;
    sym <= '{symbol: code, last: is_last};
    @(posedge clk);
    while (!sym_ready) @(posedge clk);
  endtask

  task automatic send_sequence(int len, int dominant_pct);
    logic [SYM_W-1:0] dominant;
    logic [SYM_W-1:0] pick;
    dominant = SYM_W'($urandom_range(CODE_MAX));
    for (int i = 0; i < len; i++) begin
      pick = ($urandom_range(99) < dominant_pct) ? dominant
                                                 : SYM_W'($urandom_range(CODE_MAX));
      send_request(pick, i == len - 1);
    end
    sent_in_phase += len;
  endtask

  task automatic settle();
    sym_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] scale_data, logic [CFG_W-1:0] cut_data);
    settle();
    reg_write(CFG_SCALE, scale_data);
    reg_write(CFG_CUTOFF, cut_data);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    send_idle_pct = (mode == 1) ? 66 : (mode == 3) ? 7 : 0;
    stall_pct = (mode == 2) ? 66 : (mode == 3) ? 7 : 0;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] scale_data;
    logic [CFG_W-1:0] cut_data;
    logic [CUT_W-1:0] cut;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Settings straight from reset: zero scale, so every penalty is zero.
    send_request(6'd5, 1'b1);

    settle();
    reg_write(CFG_SCALE, 24'hFFFFFF);
    reg_write(CFG_CUTOFF, 24'h000000);
    reg_write(CFG_SPARE_LO, CFG_W'($urandom));
    reg_write(CFG_SPARE_HI, CFG_W'($urandom));
    cfg_we <= 1'b0;
    send_request(6'd0, 1'b1);
    send_request(6'd63, 1'b1);
    send_request(6'd63, 1'b0);
    send_request(6'd63, 1'b0);
    send_request(6'd63, 1'b1);
    send_request(6'd0, 1'b0);
    send_request(6'd1, 1'b0);
    send_request(6'd2, 1'b0);
    send_request(6'd3, 1'b1);

    // The upper data bits lie outside the cutoff register and must be dropped.
    apply_settings(24'h800000, 24'hFE8000);
    send_request(6'd7, 1'b0);
    send_request(6'd7, 1'b0);
    send_request(6'd9, 1'b0);
    send_request(6'd9, 1'b1);
    send_request(6'd1, 1'b0);
    send_request(6'd2, 1'b0);
    send_request(6'd3, 1'b1);
    send_request(6'd4, 1'b0);
    send_request(6'd4, 1'b0);
    send_request(6'd4, 1'b0);
    send_request(6'd5, 1'b1);

    apply_settings(24'hFFFFFF, 24'h010000);
    send_request(6'd1, 1'b0);
    send_request(6'd1, 1'b1);
    apply_settings(24'hFFFFFF, 24'hFFFFFF);
    send_request(6'd2, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(3))
        0: scale_data = '0;
        1: scale_data = 24'hFFFFFF;
        default: scale_data = CFG_W'($urandom);
      endcase
      case ($urandom_range(5))
        0: cut = '0;
        1: cut = ONE_Q16;
        2: cut = CUT_W'($urandom_range(65537, 131071));
        default: cut = CUT_W'($urandom_range(65536));
      endcase
      cut_data = CFG_W'($urandom);
      cut_data[CUT_W-1:0] = cut;
      apply_settings(scale_data, cut_data);
      set_idling(phase % 4);
      if (phase == 0) begin
        send_sequence(SEQ_LIMIT, 90);
        send_sequence(SEQ_LIMIT + 3, 90);
      end
      if (phase == 4) hold_off = 1'b1;
      sent_in_phase = 0;
      while (sent_in_phase < 70) send_sequence($urandom_range(1, 12), $urandom_range(100));
    end

    set_idling(0);
    sym_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
